// ----- rtl/core/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg: Mandelbrot escape-time shared types and constants
// Transaction payloads, sequencer states, register indexes and the
// 32-bit saturation helper.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int FRAC_BITS = 26;
  localparam int SUM_W     = 42;  // wide enough for every pre-saturation sum

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE  = 3'd2;
  localparam logic [2:0] REG_MAX_ITER   = 3'd3;
  localparam logic [2:0] REG_ESCAPE_RSQ = 3'd4;

  // reset values
  localparam logic signed [31:0] ORIGIN_X_RST   = -32'sd134217728;
  localparam logic signed [31:0] ORIGIN_Y_RST   = -32'sd67108864;
  localparam logic [30:0]        STEP_SIZE_RST  = 31'd196608;
  localparam logic [15:0]        MAX_ITER_RST   = 16'd256;
  localparam logic [30:0]        ESCAPE_RSQ_RST = 31'd268435456;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
  } in_t;

  typedef struct packed {
    logic [9:0]  col_out;
    logic [9:0]  row_out;
    logic [15:0] iterations;
    logic        inside_res;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_CX,
    ST_MUL_CY,
    ST_SQ_X,
    ST_SQ_Y,
    ST_CHECK,
    ST_STEP
  } state_t;

  // {saturated, value} of a wide signed sum clamped to signed 32 bits
  function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [32:0] r;
    if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31])) begin
      r = {1'b0, v[31:0]};
    end else if (v[SUM_W-1]) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b1, 32'h7FFF_FFFF};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mbe_mul.sv -----
// ----------------------------------------------------------------------------
// mbe_mul: shared signed multiplier
// 32x32 signed multiply with the full 64-bit product registered.
// ----------------------------------------------------------------------------
module mbe_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- rtl/core/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time iteration for one pixel per transaction
// Maps a pixel to c = origin + step_size * pixel (signed Q6.26) and iterates
// z = z^2 + c until the limit is reached or |z|^2 exceeds the squared escape radius.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The block then
// stays busy while it takes N steps (1 up to max_iterations), and done pulses
// for one cycle right after busy falls with the result on result. The receiver
// cannot stall: the result is valid only in the done cycle. Every step issues
// three products (x*x, y*y, x*y) on one shared 32x32 multiplier, then forms
// and saturates the new z; before the first step the block forms c and its
// squares. With max_iterations of 0 no step is taken: done follows start in the
// next cycle, busy never rises, and the result reads 0 iterations, inside.
// Configuration writes take effect at once and belong only to idle periods.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mbe_pkg::in_t      item,
  output logic              done,
  output mbe_pkg::out_t     result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  // configuration registers
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [30:0]        step_size;
  logic [15:0]        max_iterations;
  logic [30:0]        escape_radius_sq;

  // sequencer and datapath registers
  mbe_pkg::state_t    state, state_next;
  mbe_pkg::in_t       pix;
  logic signed [31:0] cx, cy, zx, zy;
  logic signed [37:0] xx, yy;        // squares >> 26, nonnegative
  logic [15:0]        count;
  logic               first;         // squares of c: no test, no count
  logic               sat_step;      // new z was clamped

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  // combinational datapath
  logic signed [mbe_pkg::SUM_W-1:0] c_sum, nx_sum, ny_sum;
  logic [32:0]        c_sat, nx_sat, ny_sat;
  logic signed [38:0] xy2;
  logic signed [37:0] sq_now;
  logic [38:0]        mag;
  logic [15:0]        count_inc;
  logic               escape, finish;

  mbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x         <= mbe_pkg::ORIGIN_X_RST;
      origin_y         <= mbe_pkg::ORIGIN_Y_RST;
      step_size        <= mbe_pkg::STEP_SIZE_RST;
      max_iterations   <= mbe_pkg::MAX_ITER_RST;
      escape_radius_sq <= mbe_pkg::ESCAPE_RSQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::REG_ORIGIN_X:   origin_x         <= cfg_data;
        mbe_pkg::REG_ORIGIN_Y:   origin_y         <= cfg_data;
        mbe_pkg::REG_STEP_SIZE:  step_size        <= cfg_data[30:0];
        mbe_pkg::REG_MAX_ITER:   max_iterations   <= cfg_data[15:0];
        mbe_pkg::REG_ESCAPE_RSQ: escape_radius_sq <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // c = origin + step * pixel; the product is nonnegative and below 2^41
  assign c_sum = (state == mbe_pkg::ST_MUL_CY)
               ? {{10{origin_x[31]}}, origin_x} + prod[41:0]
               : {{10{origin_y[31]}}, origin_y} + prod[41:0];
  assign c_sat = mbe_pkg::sat32(c_sum);

  // new z from xx, yy and the x*y product landing in the step cycle
  assign xy2    = prod[63:25];
  assign nx_sum = {{4{xx[37]}}, xx} - {{4{yy[37]}}, yy} + {{10{cx[31]}}, cx};
  assign ny_sum = {{3{xy2[38]}}, xy2} + {{10{cy[31]}}, cy};
  assign nx_sat = mbe_pkg::sat32(nx_sum);
  assign ny_sat = mbe_pkg::sat32(ny_sum);

  // escape test on the squares of the new z
  assign sq_now    = prod[63:26];
  assign mag       = {1'b0, xx} + {1'b0, sq_now};
  assign count_inc = count + 16'd1;
  assign escape    = sat_step || (|xx[37:31]) || (|sq_now[37:31]) || (|mag[38:31])
                   || (mag > {8'd0, escape_radius_sq});
  assign finish    = escape || (count_inc == max_iterations);

  assign busy = (state != mbe_pkg::ST_IDLE);

  // sequencer: next state and multiplier operands
  always_comb begin
    state_next = state;
    mul_a      = zx;
    mul_b      = zy;
    case (state)
      mbe_pkg::ST_IDLE: begin
        if (start && (max_iterations != 16'd0)) begin
          state_next = mbe_pkg::ST_MUL_CX;
        end
      end
      mbe_pkg::ST_MUL_CX: begin
        mul_a      = {1'b0, step_size};
        mul_b      = {22'd0, pix.col};
        state_next = mbe_pkg::ST_MUL_CY;
      end
      mbe_pkg::ST_MUL_CY: begin
        mul_a      = {1'b0, step_size};
        mul_b      = {22'd0, pix.row};
        state_next = mbe_pkg::ST_SQ_X;
      end
      mbe_pkg::ST_SQ_X: begin
        mul_a      = zx;
        mul_b      = zx;
        state_next = mbe_pkg::ST_SQ_Y;
      end
      mbe_pkg::ST_SQ_Y: begin
        mul_a      = zy;
        mul_b      = zy;
        state_next = mbe_pkg::ST_CHECK;
      end
      mbe_pkg::ST_CHECK: begin
        // x*y for the next step is issued here either way
        if (!first && finish) begin
          state_next = mbe_pkg::ST_IDLE;
        end else begin
          state_next = mbe_pkg::ST_STEP;
        end
      end
      mbe_pkg::ST_STEP: begin
        state_next = mbe_pkg::ST_SQ_X;
      end
      default: begin
        state_next = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == mbe_pkg::ST_IDLE) && start && (max_iterations == 16'd0))
           || ((state == mbe_pkg::ST_CHECK) && !first && finish);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mbe_pkg::ST_IDLE: begin
        pix   <= item;
        count <= 16'd0;
        first <= 1'b1;
        result.col_out    <= item.col;
        result.row_out    <= item.row;
        result.iterations <= 16'd0;
        result.inside_res <= 1'b1;
      end
      mbe_pkg::ST_MUL_CY: begin
        cx <= c_sat[31:0];
        zx <= c_sat[31:0];
      end
      mbe_pkg::ST_SQ_X: begin
        if (first) begin
          cy <= c_sat[31:0];
          zy <= c_sat[31:0];
        end
      end
      mbe_pkg::ST_SQ_Y: begin
        xx <= sq_now;
      end
      mbe_pkg::ST_CHECK: begin
        yy <= sq_now;
        if (!first) begin
          count             <= count_inc;
          result.col_out    <= pix.col;
          result.row_out    <= pix.row;
          result.iterations <= count_inc;
          result.inside_res <= (count_inc == max_iterations);
        end
        first <= 1'b0;
      end
      mbe_pkg::ST_STEP: begin
        zx       <= nx_sat[31:0];
        zy       <= ny_sat[31:0];
        sat_step <= nx_sat[32] || ny_sat[32];
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a result only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == mbe_pkg::ST_IDLE))
    else $error("done while sequencer busy");

  // a result comes from a final test or from a zero-limit transaction
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == mbe_pkg::ST_CHECK) ||
             ($past(state) == mbe_pkg::ST_IDLE && $past(start)))
    else $error("done without a source");

  // zero iterations only happen on the inside path
  a_zero_inside: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.iterations != 16'd0) || result.inside_res)
    else $error("zero iterations reported as escaped");

  // every z update in the step state directly follows the check state
  a_step_order: assert property (@(posedge clk) disable iff (rst)
    (state == mbe_pkg::ST_STEP) |-> ($past(state) == mbe_pkg::ST_CHECK))
    else $error("step entered out of order");
`endif

endmodule
